>>> rtl/psu_pkg.sv
package psu_pkg;

  localparam int SWARM_SIZE = 64;
  localparam int IDX_W      = $clog2(SWARM_SIZE);
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [1:0] {
    REQ_INIT   = 2'd0,
    REQ_MOVE   = 2'd1,
    REQ_REPORT = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INERTIA   = 3'd0,
    CFG_COGNITIVE = 3'd1,
    CFG_SOCIAL    = 3'd2,
    CFG_VEL_LIM   = 3'd3,
    CFG_POS_LIM   = 3'd4
  } cfg_e;

  localparam logic [15:0] INERTIA_RST   = 16'd0;
  localparam logic [15:0] COGNITIVE_RST = 16'd4096;
  localparam logic [15:0] SOCIAL_RST    = 16'd4096;
  localparam logic [14:0] VEL_LIM_RST   = 15'd819;
  localparam logic [14:0] POS_LIM_RST   = 15'd14336;

  typedef struct packed {
    logic accept;
    logic mul_one;
    logic mul_two;
    logic sum;
    logic commit;
  } psu_cmd_t;

  typedef struct packed {
    logic is_move;
  } psu_status_t;

endpackage

>>> rtl/psu_ctrl.sv
module psu_ctrl
  import psu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  psu_status_t status_i,
  output psu_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_MUL1   = 6'b000100,
    S_MUL2   = 6'b001000,
    S_SUM    = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (start) state_d = S_DECODE;
      S_DECODE: state_d = status_i.is_move ? S_MUL1 : S_DONE;
      S_MUL1:   state_d = S_MUL2;
      S_MUL2:   state_d = S_SUM;
      S_SUM:    state_d = S_DONE;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign cmd_o.accept  = (state_q == S_IDLE) && start;
  assign cmd_o.mul_one = (state_q == S_MUL1);
  assign cmd_o.mul_two = (state_q == S_MUL2);
  assign cmd_o.sum     = (state_q == S_SUM);
  assign cmd_o.commit  = (state_q == S_DONE);

endmodule

>>> rtl/psu_datapath.sv
module psu_datapath
  import psu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  psu_cmd_t             cmd_i,
  output psu_status_t          status_o,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  logic [1:0]           req_type_i,
  input  logic [5:0]           particle_i,
  input  logic signed [15:0]   init_x_i,
  input  logic signed [15:0]   init_y_i,
  input  logic signed [15:0]   init_vx_i,
  input  logic signed [15:0]   init_vy_i,
  input  logic [15:0]          rand_one_i,
  input  logic [15:0]          rand_two_i,
  input  logic signed [31:0]   fitness_in_i,
  output logic                 result_valid_o,
  output logic [5:0]           out_particle_o,
  output logic signed [15:0]   new_x_o,
  output logic signed [15:0]   new_y_o,
  output logic signed [15:0]   best_x_o,
  output logic signed [15:0]   best_y_o,
  output logic signed [31:0]   best_fitness_o,
  output logic                 best_valid_o
);

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [31:0] bf;
  } entry_t;

  entry_t mem [SWARM_SIZE];

  logic [15:0] w_q, c1_q, c2_q;
  logic [14:0] vlim_q, plim_q;

  logic [1:0]         type_q;
  logic [5:0]         part_q;
  logic               inrange_q;
  logic [IDX_W-1:0]   addr_q;
  logic signed [15:0] ix_q, iy_q, ivx_q, ivy_q;
  logic [15:0]        r1_q, r2_q;
  logic signed [31:0] fit_q;
  entry_t             rd_q;

  logic signed [15:0] gx_q, gy_q;
  logic signed [31:0] gf_q;
  logic               gv_q;

  logic [31:0]        k1_q, k2_q;
  logic signed [20:0] inx_q, iny_q;
  logic signed [16:0] d1x_q, d1y_q, d2x_q, d2y_q;
  logic signed [21:0] cx_q, cy_q, sx_q, sy_q;
  logic signed [15:0] nvx_q, nvy_q;

  logic [31:0]      p_ext;
  logic [IDX_W-1:0] addr_in;

  assign p_ext   = 32'(particle_i);
  assign addr_in = p_ext[IDX_W-1:0];
  assign status_o.is_move = (type_q == REQ_MOVE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= INERTIA_RST;
      c1_q   <= COGNITIVE_RST;
      c2_q   <= SOCIAL_RST;
      vlim_q <= VEL_LIM_RST;
      plim_q <= POS_LIM_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_INERTIA:   w_q    <= cfg_data_i;
        CFG_COGNITIVE: c1_q   <= cfg_data_i;
        CFG_SOCIAL:    c2_q   <= cfg_data_i;
        CFG_VEL_LIM:   vlim_q <= cfg_data_i[14:0];
        CFG_POS_LIM:   plim_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      type_q    <= req_type_i;
      part_q    <= particle_i;
      inrange_q <= (p_ext < 32'(SWARM_SIZE));
      addr_q    <= addr_in;
      ix_q      <= init_x_i;
      iy_q      <= init_y_i;
      ivx_q     <= init_vx_i;
      ivy_q     <= init_vy_i;
      r1_q      <= rand_one_i;
      r2_q      <= rand_two_i;
      fit_q     <= fitness_in_i;
      rd_q      <= mem[addr_in];
    end
  end

  // move arithmetic
  logic signed [16:0] w_s;
  logic signed [32:0] prod_ix, prod_iy;
  logic signed [32:0] k1_s, k2_s;
  logic signed [49:0] pc_x, pc_y, ps_x, ps_y;
  logic signed [23:0] sum_x, sum_y, vlim_s;

  assign w_s     = $signed({1'b0, w_q});
  assign prod_ix = w_s * rd_q.vx;
  assign prod_iy = w_s * rd_q.vy;
  assign k1_s    = $signed({1'b0, k1_q});
  assign k2_s    = $signed({1'b0, k2_q});
  assign pc_x    = k1_s * d1x_q;
  assign pc_y    = k1_s * d1y_q;
  assign ps_x    = k2_s * d2x_q;
  assign ps_y    = k2_s * d2y_q;
  assign vlim_s  = $signed({9'd0, vlim_q});
  assign sum_x   = {{3{inx_q[20]}}, inx_q} + {{2{cx_q[21]}}, cx_q} + {{2{sx_q[21]}}, sx_q};
  assign sum_y   = {{3{iny_q[20]}}, iny_q} + {{2{cy_q[21]}}, cy_q} + {{2{sy_q[21]}}, sy_q};

  function automatic logic signed [15:0] clamp_v(logic signed [23:0] v,
                                                 logic signed [23:0] lim);
    logic signed [23:0] r;
    r = v;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    return r[15:0];
  endfunction

  function automatic logic signed [15:0] clamp_p(logic signed [16:0] v,
                                                 logic signed [16:0] lim);
    logic signed [16:0] r;
    r = v;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    return r[15:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_one) begin
      k1_q  <= c1_q * r1_q;
      k2_q  <= c2_q * r2_q;
      inx_q <= prod_ix[32:12];
      iny_q <= prod_iy[32:12];
      d1x_q <= {rd_q.bx[15], rd_q.bx} - {rd_q.px[15], rd_q.px};
      d1y_q <= {rd_q.by[15], rd_q.by} - {rd_q.py[15], rd_q.py};
      d2x_q <= {gx_q[15], gx_q} - {rd_q.px[15], rd_q.px};
      d2y_q <= {gy_q[15], gy_q} - {rd_q.py[15], rd_q.py};
    end
    if (cmd_i.mul_two) begin
      cx_q <= pc_x[49:28];
      cy_q <= pc_y[49:28];
      sx_q <= ps_x[49:28];
      sy_q <= ps_y[49:28];
    end
    if (cmd_i.sum) begin
      nvx_q <= clamp_v(sum_x, vlim_s);
      nvy_q <= clamp_v(sum_y, vlim_s);
    end
  end

  // commit
  entry_t             e_new;
  logic               wr_en, g_upd;
  logic signed [16:0] plim_s;

  assign plim_s = $signed({2'd0, plim_q});

  always_comb begin
    e_new = rd_q;
    wr_en = 1'b0;
    g_upd = 1'b0;
    unique case (type_q)
      REQ_INIT: begin
        e_new.px = ix_q;
        e_new.py = iy_q;
        e_new.vx = ivx_q;
        e_new.vy = ivy_q;
        e_new.bx = ix_q;
        e_new.by = iy_q;
        e_new.bf = fit_q;
        wr_en    = 1'b1;
        g_upd    = !gv_q || (fit_q > gf_q);
      end
      REQ_MOVE: begin
        e_new.vx = nvx_q;
        e_new.vy = nvy_q;
        e_new.px = clamp_p({rd_q.px[15], rd_q.px} + {nvx_q[15], nvx_q}, plim_s);
        e_new.py = clamp_p({rd_q.py[15], rd_q.py} + {nvy_q[15], nvy_q}, plim_s);
        wr_en    = 1'b1;
      end
      REQ_REPORT: begin
        if (fit_q > rd_q.bf) begin
          e_new.bx = rd_q.px;
          e_new.by = rd_q.py;
          e_new.bf = fit_q;
        end
        wr_en = 1'b1;
        g_upd = !gv_q || (fit_q > gf_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && inrange_q && wr_en) begin
      mem[addr_q] <= e_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx_q           <= '0;
      gy_q           <= '0;
      gf_q           <= '0;
      gv_q           <= 1'b0;
      result_valid_o <= 1'b0;
      best_valid_o   <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.commit;
      if (cmd_i.commit) begin
        if (inrange_q && g_upd) begin
          gx_q <= e_new.px;
          gy_q <= e_new.py;
          gf_q <= fit_q;
          gv_q <= 1'b1;
        end
        best_valid_o <= gv_q || (inrange_q && g_upd);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_particle_o <= part_q;
      new_x_o        <= inrange_q ? e_new.px : '0;
      new_y_o        <= inrange_q ? e_new.py : '0;
      best_x_o       <= (inrange_q && g_upd) ? e_new.px : gx_q;
      best_y_o       <= (inrange_q && g_upd) ? e_new.py : gy_q;
      best_fitness_o <= (inrange_q && g_upd) ? fit_q : gf_q;
    end
  end

endmodule

>>> rtl/particle_swarm_update_engine.sv
// Particle swarm update engine: per-particle state for SWARM_SIZE particles
// lives in one on-chip memory. An item is taken when start is high and busy is
// low; its result appears for exactly one cycle with result_valid_o and must be
// captured then. Every item reads its state at accept and commits after decode;
// a move adds two dependent multiply stages and a sum and clamp step before its
// position update and write-back. busy drops in the strobe cycle, so the next
// item can be taken while the result is shown. Configuration words are always
// accepted (cfg_ready_o is tied high) and must be written while idle.
module particle_swarm_update_engine
  import psu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  logic [1:0]           req_type_i,
  input  logic [5:0]           particle_i,
  input  logic signed [15:0]   init_x_i,
  input  logic signed [15:0]   init_y_i,
  input  logic signed [15:0]   init_vx_i,
  input  logic signed [15:0]   init_vy_i,
  input  logic [15:0]          rand_one_i,
  input  logic [15:0]          rand_two_i,
  input  logic signed [31:0]   fitness_in_i,
  output logic                 result_valid_o,
  output logic [5:0]           out_particle_o,
  output logic signed [15:0]   new_x_o,
  output logic signed [15:0]   new_y_o,
  output logic signed [15:0]   best_x_o,
  output logic signed [15:0]   best_y_o,
  output logic signed [31:0]   best_fitness_o,
  output logic                 best_valid_o
);

  psu_cmd_t    cmd;
  psu_status_t status;

  assign cfg_ready_o = 1'b1;

  psu_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  psu_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .particle_i     (particle_i),
    .init_x_i       (init_x_i),
    .init_y_i       (init_y_i),
    .init_vx_i      (init_vx_i),
    .init_vy_i      (init_vy_i),
    .rand_one_i     (rand_one_i),
    .rand_two_i     (rand_two_i),
    .fitness_in_i   (fitness_in_i),
    .result_valid_o (result_valid_o),
    .out_particle_o (out_particle_o),
    .new_x_o        (new_x_o),
    .new_y_o        (new_y_o),
    .best_x_o       (best_x_o),
    .best_y_o       (best_y_o),
    .best_fitness_o (best_fitness_o),
    .best_valid_o   (best_valid_o)
  );

endmodule

>>> rtl/psu_checker.sv
module psu_checker
  import psu_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input logic best_valid_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while busy");

  a_fell_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("item finished without result");

  a_single_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_best_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_valid_o |=> best_valid_o)
    else $error("global best valid dropped");

endmodule

bind particle_swarm_update_engine psu_checker u_psu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .best_valid_o   (best_valid_o)
);
